FILE: rtl/rmse_pkg.sv
// Shared types and constants for the RMSE accumulator.
package rmse_pkg;

  localparam int COUNT_BITS_DEF = 20;
  localparam int LANES = 4;
  localparam int DATA_W = 32;
  localparam int SUM_W = 64;
  localparam int PCOUNT_W = 20;
  localparam int DIV_STEPS_W = 7;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_DIV,
    ST_ROOT,
    ST_OUT
  } rmse_state_t;

  typedef struct packed {
    logic acc_en;
    logic div_start;
    logic div_step;
    logic root_start;
    logic root_step;
    logic lane_next;
    logic load_out;
    logic clear;
  } rmse_cmd_t;

  typedef struct packed {
    logic step_last;
    logic lane_last;
  } rmse_stat_t;

  typedef struct packed {
    logic [DATA_W-1:0] est_a;
    logic [DATA_W-1:0] est_b;
    logic [DATA_W-1:0] est_c;
    logic [DATA_W-1:0] est_d;
    logic [DATA_W-1:0] truth_a;
    logic [DATA_W-1:0] truth_b;
    logic [DATA_W-1:0] truth_c;
    logic [DATA_W-1:0] truth_d;
    logic final_pair;
  } pair_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] rmse_a;
    logic [DATA_W-1:0] rmse_b;
    logic [DATA_W-1:0] rmse_c;
    logic [DATA_W-1:0] rmse_d;
    logic [PCOUNT_W-1:0] pair_count;
    logic overflow_seen;
  } rmse_item_t;

endpackage

FILE: rtl/rmse_if.sv
// Valid/ready channel interface carrying one payload item.
interface rmse_if #(
  parameter type payload_t = logic
);
  logic valid;
  logic ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/rmse_ctrl.sv
// Controller sequencing accumulation, per-lane division, root and result.
module rmse_ctrl
  import rmse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_final,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  rmse_stat_t stat,
  output rmse_cmd_t  cmd
);

  rmse_state_t state, state_next;
  logic out_full, out_full_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACC;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      out_full <= out_full_next;
    end
  end

  always_comb begin
    state_next = state;
    out_full_next = out_full && !out_ready;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = out_full;
    case (state)
      ST_ACC: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.acc_en = 1'b1;
          if (in_final) begin
            state_next = ST_DIV;
            cmd.div_start = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.step_last) begin
          state_next = ST_ROOT;
          cmd.root_start = 1'b1;
        end
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (stat.step_last) begin
          if (stat.lane_last) begin
            state_next = ST_OUT;
          end else begin
            state_next = ST_DIV;
            cmd.lane_next = 1'b1;
            cmd.div_start = 1'b1;
          end
        end
      end
      ST_OUT: begin
        if (!out_full || out_ready) begin
          state_next = ST_ACC;
          cmd.load_out = 1'b1;
          cmd.clear = 1'b1;
          out_full_next = 1'b1;
        end
      end
      default: state_next = ST_ACC;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) (state != ST_ACC) |-> !in_ready)
    else $error("input taken while a result is being computed");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACC && in_valid && in_final) |=> state == ST_DIV)
    else $error("final item did not start division");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result register overwritten");

endmodule

FILE: rtl/rmse_dp.sv
// Datapath: difference, square, saturating sums, serial divider and root.
module rmse_dp
  import rmse_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic signed [DATA_W-1:0]    est [LANES],
  input  logic signed [DATA_W-1:0]    truth [LANES],
  input  rmse_cmd_t                   cmd,
  output rmse_stat_t                  stat,
  output logic [DATA_W-1:0]           rmse [LANES],
  output logic [PCOUNT_W-1:0]         pair_count,
  output logic                        overflow_seen
);

  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic [SUM_W-1:0] sums [LANES];
  logic [COUNT_BITS-1:0] pairs;
  logic sat;
  logic [1:0] lane;
  logic [1:0] lane_sel;
  logic [DIV_STEPS_W-1:0] step;
  logic [SUM_W-1:0] quo;
  logic [COUNT_BITS:0] rem;
  logic [SUM_W-1:0] rv;
  logic [SUM_W-1:0] root;
  logic [SUM_W-1:0] bitv;
  logic [DATA_W-1:0] lane_root [LANES];

  logic [LANES-1:0] dsat, ssat;
  logic [SUM_W-1:0] sq [LANES];
  logic [SUM_W:0] sadd [LANES];

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      logic signed [DATA_W:0] d;
      logic [DATA_W-1:0] mag;
      d = {est[k][DATA_W-1], est[k]} - {truth[k][DATA_W-1], truth[k]};
      dsat[k] = d[DATA_W] != d[DATA_W-1];
      if (dsat[k]) begin
        mag = d[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
        mag = d[DATA_W-1] ? DATA_W'(-d[DATA_W-1:0]) : d[DATA_W-1:0];
      end
      sq[k] = SUM_W'(mag) * SUM_W'(mag);
      sadd[k] = {1'b0, sums[k]} + {1'b0, sq[k]};
      ssat[k] = sadd[k][SUM_W];
    end
  end

  // Restoring division, one quotient bit per cycle, then a bit-pair root.
  logic [COUNT_BITS+1:0] trial;
  logic [SUM_W-1:0] rb;
  always_comb begin
    trial = {rem, quo[SUM_W-1]} - {1'b0, 1'b0, pairs};
    rb = root + bitv;
    lane_sel = cmd.lane_next ? lane + 2'd1 : lane;
    stat.step_last = (cmd.div_step && step == DIV_STEPS_W'(SUM_W-1)) ||
                     (cmd.root_step && (bitv[1:0] != 2'b00));
    stat.lane_last = lane == 2'(LANES-1);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int k = 0; k < LANES; k++) sums[k] <= '0;
      pairs <= '0;
      sat <= 1'b0;
      lane <= '0;
    end else begin
      if (cmd.acc_en) begin
        for (int k = 0; k < LANES; k++) begin
          sums[k] <= ssat[k] ? '1 : sadd[k][SUM_W-1:0];
        end
        if (pairs == CountMax) begin
          sat <= 1'b1;
        end else begin
          pairs <= pairs + 1'b1;
          if (|dsat || |ssat) sat <= 1'b1;
        end
      end
      if (cmd.lane_next) lane <= lane + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo <= cmd.acc_en ? (ssat[lane_sel] ? '1 : sadd[lane_sel][SUM_W-1:0]) : sums[lane_sel];
      rem <= '0;
      step <= '0;
    end else if (cmd.div_step) begin
      step <= step + 1'b1;
      if (!trial[COUNT_BITS+1]) begin
        rem <= trial[COUNT_BITS:0];
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= {rem[COUNT_BITS-1:0], quo[SUM_W-1]};
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
    end
    if (cmd.root_start) begin
      rv <= {quo[SUM_W-2:0], ~trial[COUNT_BITS+1]};
      root <= '0;
      bitv <= {2'b01, {(SUM_W-2){1'b0}}};
    end else if (cmd.root_step) begin
      if (rv >= rb) begin
        rv <= rv - rb;
        root <= (root >> 1) + bitv;
      end else begin
        root <= root >> 1;
      end
      bitv <= bitv >> 2;
      if (bitv[1:0] != 2'b00) begin
        lane_root[lane] <= DATA_W'((rv >= rb) ? (root >> 1) + bitv : root >> 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LANES; k++) rmse[k] <= '0;
      pair_count <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.load_out) begin
      for (int k = 0; k < LANES; k++) rmse[k] <= lane_root[k];
      pair_count <= PCOUNT_W'(pairs);
      overflow_seen <= sat;
    end
  end

endmodule

FILE: rtl/rmse_accumulator.sv
// Top level of the RMSE accumulator.
// Accumulation sustains one item per cycle, except while a result is being computed, when input is held off.
// The final item starts a serial pass of divider steps and then root steps for each lane in turn,
// then the result register is loaded, which waits while an earlier result is still unaccepted;
// the load marks the result valid and returns the block to accepting input.
// Synchronous reset clears sums, count, overflow flag and the result register.
module rmse_accumulator
  import rmse_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input logic clk,
  input logic rst,
  rmse_if.sink in,
  rmse_if.source out
);

  rmse_cmd_t cmd;
  rmse_stat_t stat;
  logic signed [DATA_W-1:0] est [LANES];
  logic signed [DATA_W-1:0] truth [LANES];
  logic [DATA_W-1:0] rmse [LANES];
  logic [PCOUNT_W-1:0] pair_count;
  logic overflow_seen;

  assign est[0] = in.data.est_a;
  assign est[1] = in.data.est_b;
  assign est[2] = in.data.est_c;
  assign est[3] = in.data.est_d;
  assign truth[0] = in.data.truth_a;
  assign truth[1] = in.data.truth_b;
  assign truth[2] = in.data.truth_c;
  assign truth[3] = in.data.truth_d;

  assign out.data.rmse_a = rmse[0];
  assign out.data.rmse_b = rmse[1];
  assign out.data.rmse_c = rmse[2];
  assign out.data.rmse_d = rmse[3];
  assign out.data.pair_count = pair_count;
  assign out.data.overflow_seen = overflow_seen;

  rmse_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in.valid), .in_final(in.data.final_pair), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready),
    .stat(stat), .cmd(cmd)
  );

  rmse_dp #(.COUNT_BITS(COUNT_BITS)) u_dp (
    .clk(clk), .rst(rst), .est(est), .truth(truth), .cmd(cmd), .stat(stat),
    .rmse(rmse), .pair_count(pair_count), .overflow_seen(overflow_seen)
  );

endmodule

FILE: dv/rmse_accumulator_tb.sv
// Self-checking testbench for rmse_accumulator: directed table, random sets and a checker.
`timescale 1ns / 1ps

module rmse_accumulator_tb;
  import rmse_pkg::*;

  typedef struct {
    pair_item_t stim;
    bit typed;
    rmse_item_t want;
  } table_row_t;

  localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
  localparam logic [31:0] MINV = 32'h8000_0000;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [63:0] SUM_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_BITS_DEF) - 64'd1;
  localparam int ROWS = 11;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rmse_if #(.payload_t(pair_item_t)) pair_ch ();
  rmse_if #(.payload_t(rmse_item_t)) rmse_ch ();

  rmse_accumulator dut (
    .clk(clk),
    .rst(rst),
    .in(pair_ch),
    .out(rmse_ch)
  );

  always #5 clk = ~clk;

  logic [63:0] lane_sums [LANES];
  logic [63:0] pairs_seen;
  bit sat_seen;
  rmse_item_t rmse_queue [$];
  int errors = 0;
  int results_seen = 0;
  int pairs_sent = 0;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;
  bit pause_done = 1'b0;
  bit relaxed_sink = 1'b0;
  table_row_t rows [ROWS];

  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic void clear_sums();
    for (int k = 0; k < LANES; k++) lane_sums[k] = 64'd0;
    pairs_seen = 64'd0;
    sat_seen = 1'b0;
  endfunction

  // Accumulates one pair; returns 1 and fills res when the pair closes a set.
  function automatic bit accumulate_pair(pair_item_t p, output rmse_item_t res);
    logic [31:0] est [LANES];
    logic [31:0] tru [LANES];
    logic [31:0] root [LANES];
    longint d;
    logic [63:0] mag;
    logic [63:0] sq;
    est = '{p.est_a, p.est_b, p.est_c, p.est_d};
    tru = '{p.truth_a, p.truth_b, p.truth_c, p.truth_d};
    res = '0;
    for (int k = 0; k < LANES; k++) begin
      d = longint'($signed(est[k])) - longint'($signed(tru[k]));
      if (d > 64'sd2147483647) begin
        d = 64'sd2147483647;
        sat_seen = 1'b1;
      end else if (d < -64'sd2147483648) begin
        d = -64'sd2147483648;
        sat_seen = 1'b1;
      end
      mag = (d < 0) ? 64'(-d) : 64'(d);
      sq = mag * mag;
      if (lane_sums[k] > SUM_MAX - sq) begin
        lane_sums[k] = SUM_MAX;
        sat_seen = 1'b1;
      end else begin
        lane_sums[k] = lane_sums[k] + sq;
      end
    end
    if (pairs_seen >= COUNT_MAX) begin
      pairs_seen = COUNT_MAX;
      sat_seen = 1'b1;
    end else begin
      pairs_seen = pairs_seen + 1;
    end
    if (!p.final_pair) return 1'b0;
    for (int k = 0; k < LANES; k++) root[k] = 32'(floor_root(lane_sums[k] / pairs_seen));
    res.rmse_a = root[0];
    res.rmse_b = root[1];
    res.rmse_c = root[2];
    res.rmse_d = root[3];
    res.pair_count = pairs_seen[PCOUNT_W-1:0];
    res.overflow_seen = sat_seen;
    clear_sums();
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH result %0d %s: got %0h, expected %0h", results_seen, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    rmse_item_t got;
    rmse_item_t want;
    if (!rst && rmse_ch.valid && rmse_ch.ready) begin
      got = rmse_ch.data;
      if (rmse_queue.size() == 0) begin
        $display("MISMATCH result %0d arrived with nothing expected", results_seen);
        errors++;
      end else begin
        want = rmse_queue.pop_front();
        if (got.rmse_a !== want.rmse_a) report_mismatch("rmse_a", got.rmse_a, want.rmse_a);
        if (got.rmse_b !== want.rmse_b) report_mismatch("rmse_b", got.rmse_b, want.rmse_b);
        if (got.rmse_c !== want.rmse_c) report_mismatch("rmse_c", got.rmse_c, want.rmse_c);
        if (got.rmse_d !== want.rmse_d) report_mismatch("rmse_d", got.rmse_d, want.rmse_d);
        if (got.pair_count !== want.pair_count) begin
          report_mismatch("pair_count", got.pair_count, want.pair_count);
        end
        if (got.overflow_seen !== want.overflow_seen) begin
          report_mismatch("overflow_seen", got.overflow_seen, want.overflow_seen);
        end
      end
      results_seen++;
    end
  end

  // The receiver normally stalls on a random pattern; on request it holds off for a long stretch.
  initial begin
    int hold_left;
    int phase_left;
    int mode;
    rmse_ch.ready = 1'b0;
    hold_left = 0;
    phase_left = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_request && hold_left == 0) begin
        hold_left = 900;
        hold_request = 1'b0;
      end
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 300);
        mode = $urandom_range(0, 2);
      end
      phase_left--;
      if (hold_left > 0) begin
        hold_left--;
        rmse_ch.ready <= 1'b0;
      end else if (relaxed_sink || mode == 0) begin
        rmse_ch.ready <= 1'b1;
      end else if (mode == 1) begin
        rmse_ch.ready <= ($urandom_range(0, 3) != 0);
      end else begin
        rmse_ch.ready <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  int burst_left = 0;

  task automatic send_pair(pair_item_t p, bit typed, rmse_item_t typed_want);
    rmse_item_t res;
    pair_ch.valid <= 1'b1;
    pair_ch.data <= p;
    do @(posedge clk); while (!pair_ch.ready);
    pairs_sent++;
    if (accumulate_pair(p, res)) rmse_queue.push_back(typed ? typed_want : res);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      if ($urandom_range(0, 2) != 0) begin
        pair_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    while (rmse_queue.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return MAXV;
      1: return MINV;
      2: return 32'd0;
      3, 4: return $urandom();
      default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    endcase
  endfunction

  function automatic pair_item_t random_pair(bit last);
    pair_item_t p;
    logic [31:0] base;
    p = '0;
    p.est_a = pick_value();
    p.est_b = pick_value();
    p.est_c = pick_value();
    p.est_d = pick_value();
    if ($urandom_range(0, 3) != 0) begin
      base = pick_value();
      p.truth_a = p.est_a + $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
      p.truth_b = p.est_b + $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
      p.truth_c = base;
      p.truth_d = p.est_d - $urandom_range(0, 255);
    end else begin
      p.truth_a = pick_value();
      p.truth_b = pick_value();
      p.truth_c = pick_value();
      p.truth_d = pick_value();
    end
    p.final_pair = last;
    return p;
  endfunction

  function automatic pair_item_t lanes_pair(logic [31:0] e, logic [31:0] t, bit last);
    pair_item_t p;
    p = '{e, e, e, e, t, t, t, t, last};
    return p;
  endfunction

  function automatic rmse_item_t typed_result(logic [31:0] r, logic [19:0] n, bit ov);
    rmse_item_t x;
    x = '{r, r, r, r, n, ov};
    return x;
  endfunction

  initial begin
    rmse_item_t none;
    int set_len;
    none = '0;
    rows[0] = '{lanes_pair(32'd0, 32'd0, 1'b1), 1'b1, typed_result(32'd0, 20'd1, 1'b0)};
    rows[1] = '{lanes_pair(MAXV, MINV, 1'b1), 1'b1, typed_result(MAXV, 20'd1, 1'b1)};
    rows[2] = '{lanes_pair(MINV, MAXV, 1'b1), 1'b1, typed_result(MINV, 20'd1, 1'b1)};
    rows[3] = '{lanes_pair(MINV, MAXV, 1'b0), 1'b0, none};
    rows[4] = '{lanes_pair(MINV, MAXV, 1'b0), 1'b0, none};
    rows[5] = '{lanes_pair(MINV, MAXV, 1'b0), 1'b0, none};
    rows[6] = '{lanes_pair(MINV, MAXV, 1'b1), 1'b1, typed_result(MAXV, 20'd4, 1'b1)};
    rows[7] = '{lanes_pair(ONE, 32'd0, 1'b1), 1'b1, typed_result(ONE, 20'd1, 1'b0)};
    rows[8] = '{lanes_pair(32'h0005_0000, 32'h0002_0000, 1'b0), 1'b0, none};
    rows[9] = '{lanes_pair(32'hFFFD_0000, ONE, 1'b1), 1'b0, none};
    rows[10] = '{'{ONE, 32'hFFFF_FFFF, MAXV, 32'd0, 32'd0, 32'd1, 32'd0, MINV, 1'b1},
                 1'b0, none};

    clear_sums();
    pair_ch.valid = 1'b0;
    pair_ch.data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    relaxed_sink = 1'b1;
    for (int i = 0; i < ROWS; i++) send_pair(rows[i].stim, rows[i].typed, rows[i].want);
    pair_ch.valid <= 1'b0;
    wait_drained();
    relaxed_sink = 1'b0;

    while (pairs_sent < 1650) begin
      if (results_seen >= 40 && !pause_done) begin
        pause_done = 1'b1;
        pair_ch.valid <= 1'b0;
        wait_drained();
      end
      if (results_seen >= 20 && !hold_done) begin
        hold_done = 1'b1;
        hold_request = 1'b1;
      end
      set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      for (int j = 1; j <= set_len; j++) send_pair(random_pair(j == set_len), 1'b0, none);
    end
    pair_ch.valid <= 1'b0;

    wait_drained();
    repeat (50) @(posedge clk);
    $display("Sent %0d pairs, checked %0d RMSE results, with saturation cases,",
             pairs_sent, results_seen);
    $display("random input gaps, receiver stalls and one long receiver hold-off.");
    if (errors == 0 && rmse_queue.size() == 0) begin
      $display("** rmse_accumulator: PASSED **");
    end else begin
      $display("** rmse_accumulator: FAILED **");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d results still expected.", rmse_queue.size());
    $display("** rmse_accumulator: FAILED **");
    $finish;
  end

endmodule

FILE: sim.f
rtl/rmse_pkg.sv
rtl/rmse_if.sv
rtl/rmse_ctrl.sv
rtl/rmse_dp.sv
rtl/rmse_accumulator.sv
dv/rmse_accumulator_tb.sv
